// ===== rtl/optical_drive_host_register_interface_defines.svh =====
// Assertion macros for the optical drive host register interface.
`ifndef OPTICAL_DRIVE_HOST_REGISTER_INTERFACE_DEFINES_SVH
`define OPTICAL_DRIVE_HOST_REGISTER_INTERFACE_DEFINES_SVH
`ifndef SYNTH
`define ODHRI_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m: label");
`define ODHRI_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m: label");
`else
`define ODHRI_ASSERT(label, clk, rst, prop)
`define ODHRI_ASSERT_RST(label, clk, prop)
`endif
`endif

// ===== rtl/odhri_pkg.sv =====
// Package: types, constants and codes of the optical drive host register interface.
package odhri_pkg;
  localparam int FifoDepthDefault = 16;
  localparam int SectorBufBytesDefault = 4096;
  localparam int DataSectorLenDefault = 2048;
  localparam int RawSectorLenDefault = 2340;

  typedef enum logic [2:0] {
    CMD_BUS_READ    = 3'd0,
    CMD_BUS_WRITE   = 3'd1,
    CMD_PUSH_RESP   = 3'd2,
    CMD_RAISE_IRQ   = 3'd3,
    CMD_POP_PARAM   = 3'd4,
    CMD_LOAD_SECTOR = 3'd5,
    CMD_SECTOR_RDY  = 3'd6,
    CMD_UNUSED      = 3'd7
  } cmd_t;

  localparam logic [1:0] REG_STATUS = 2'd0;
  localparam logic [1:0] REG_ONE    = 2'd1;
  localparam logic [1:0] REG_TWO    = 2'd2;
  localparam logic [1:0] REG_THREE  = 2'd3;

  localparam logic CFG_ADPCM = 1'b0;
  localparam logic CFG_RAW   = 1'b1;

  typedef struct packed {
    logic [2:0]  command;
    logic [1:0]  reg_offset;
    logic [7:0]  write_value;
    logic [7:0]  drive_byte;
    logic        clear_first;
    logic [2:0]  interrupt_kind;
    logic [11:0] sector_index;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       data_valid;
    logic       command_valid;
    logic [4:0] command_code;
    logic       irq_request;
  } out_word_t;

  // FIFO control: clear, push, pop.
  typedef struct packed {
    logic clr;
    logic push;
    logic pop;
  } fifo_ctl_t;
endpackage

// ===== rtl/odhri_fifo.sv =====
// Byte FIFO with clear, drop on full and registered-free head read.
module odhri_fifo #(
  parameter int Depth = odhri_pkg::FifoDepthDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  odhri_pkg::fifo_ctl_t ctl,
  input  logic [7:0]          din,
  output logic [7:0]          dout,
  output logic                empty,
  output logic                full
);
  import odhri_pkg::*;
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  logic [7:0]    mem [Depth];
  logic [AW-1:0] head, tail;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign empty = (count == '0);
  assign full  = (count == CW'(Depth));
  assign dout  = mem[head];
  assign do_pop  = ctl.pop && !empty && !ctl.clr;
  assign do_push = ctl.push && (ctl.clr || !full);

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[ctl.clr ? '0 : tail] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      head  <= '0;
      tail  <= (do_push && !rst) ? AW'(1 % Depth) : '0;
      count <= (do_push && !rst) ? CW'(1) : '0;
    end else begin
      if (do_push) begin
        tail <= (tail == AW'(Depth - 1)) ? '0 : tail + 1'b1;
      end
      if (do_pop) begin
        head <= (head == AW'(Depth - 1)) ? '0 : head + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

// ===== rtl/optical_drive_host_register_interface.sv =====
// Top level of the optical drive host register interface.
// Channel | Direction | Handshake        | Word
// in      | input     | in_valid/in_stall | odhri_pkg::in_word_t
// out     | output    | out_valid/out_stall | odhri_pkg::out_word_t
// cfg     | input     | cfg_we           | cfg_index, cfg_data
// Every word is accepted into a single pass of logic and
// its result lands in the output register at the same edge.
// The output register is the only stage; a stalled result blocks input
// (in_stall follows out_valid && out_stall), so throughput is one word a cycle while out_stall is low.
// Reset is synchronous; no clearing pass, sector and FIFO stores are unreset.
module optical_drive_host_register_interface #(
  parameter int FifoDepth      = odhri_pkg::FifoDepthDefault,
  parameter int SectorBufBytes = odhri_pkg::SectorBufBytesDefault,
  parameter int DataSectorLen  = odhri_pkg::DataSectorLenDefault,
  parameter int RawSectorLen   = odhri_pkg::RawSectorLenDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  odhri_pkg::in_word_t  in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output odhri_pkg::out_word_t out_word,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic                 cfg_data
);
  import odhri_pkg::*;
  `include "optical_drive_host_register_interface_defines.svh"

  localparam int SAW = $clog2(SectorBufBytes);
  localparam logic [12:0] DataLenSat =
    13'((DataSectorLen > SectorBufBytes) ? SectorBufBytes : DataSectorLen);
  localparam logic [12:0] RawLenSat =
    13'((RawSectorLen > SectorBufBytes) ? SectorBufBytes : RawSectorLen);

  // Configuration registers.
  logic adpcm_enable_mode, raw_sector_mode;
  always_ff @(posedge clk) begin
    if (rst) begin
      adpcm_enable_mode <= 1'b0;
      raw_sector_mode   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ADPCM: adpcm_enable_mode <= cfg_data;
        CFG_RAW:   raw_sector_mode   <= cfg_data;
        default:   ;
      endcase
    end
  end

  logic      accept;
  cmd_t      cmd;
  logic [1:0] bank_select;
  logic [4:0] irq_flag, irq_enable;
  logic [7:0] request_reg;
  logic [12:0] sector_pos, sector_len;
  logic [7:0] volume_regs [4];
  logic [7:0] sector_store [SectorBufBytes];

  fifo_ctl_t  pctl, rctl;
  logic [7:0] p_dout, r_dout, r_din;
  logic       p_empty, p_full, r_empty, r_full;
  out_word_t  res;
  logic       is_read, is_write;
  logic       sec_rd;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign cmd      = cmd_t'(in_word.command);
  assign is_read  = accept && cmd == CMD_BUS_READ;
  assign is_write = accept && cmd == CMD_BUS_WRITE;
  assign sec_rd   = is_read && in_word.reg_offset == REG_TWO && sector_pos < sector_len;

  // FIFO controls.
  always_comb begin
    pctl = '0;
    rctl = '0;
    r_din = in_word.drive_byte;
    if (is_write && bank_select == 2'd0 && in_word.reg_offset == REG_TWO) begin
      pctl.push = 1'b1;
    end
    r_din = in_word.drive_byte;
    if (is_write && bank_select == 2'd1 && in_word.reg_offset == REG_THREE) begin
      rctl.clr = in_word.write_value[2:0] != 3'd0;
      pctl.clr = in_word.write_value[6];
    end
    if (accept && cmd == CMD_POP_PARAM) begin
      pctl.pop = 1'b1;
    end
    if (accept && cmd == CMD_PUSH_RESP) begin
      rctl.push = 1'b1;
      rctl.clr  = in_word.clear_first;
    end
    if (is_read && in_word.reg_offset == REG_ONE) begin
      rctl.pop = 1'b1;
    end
  end

  odhri_fifo #(.Depth(FifoDepth)) u_param (
    .clk, .rst, .ctl(pctl), .din(in_word.write_value),
    .dout(p_dout), .empty(p_empty), .full(p_full)
  );
  odhri_fifo #(.Depth(FifoDepth)) u_resp (
    .clk, .rst, .ctl(rctl), .din(r_din),
    .dout(r_dout), .empty(r_empty), .full(r_full)
  );

  // Sector buffer: write on load, read straight into the result.
  logic [7:0] sec_q;
  always_ff @(posedge clk) begin
    if (accept && cmd == CMD_LOAD_SECTOR && {1'b0, in_word.sector_index} < 13'(SectorBufBytes)) begin
      sector_store[in_word.sector_index[SAW-1:0]] <= in_word.drive_byte;
    end
    sec_q <= sector_store[sector_pos[SAW-1:0]];
  end

  // Result word, all but the sector byte which joins from the memory port.
  logic sec_sel;
  always_comb begin
    res = '0;
    unique case (cmd)
      CMD_BUS_READ: begin
        unique case (in_word.reg_offset)
          REG_STATUS: res.read_data = {1'b0, request_reg[7], !r_empty, !p_full,
                                       p_empty, adpcm_enable_mode, bank_select};
          REG_ONE:    res.read_data = r_empty ? 8'd0 : r_dout;
          REG_TWO:    res.read_data = 8'd0;
          default:    res.read_data = {3'b111, bank_select[0] ? irq_flag : irq_enable};
        endcase
      end
      CMD_BUS_WRITE: begin
        if (in_word.reg_offset == REG_ONE && bank_select == 2'd0) begin
          res.command_valid = 1'b1;
          res.command_code  = in_word.write_value[4:0];
        end
      end
      CMD_RAISE_IRQ: res.irq_request = 1'b1;
      CMD_POP_PARAM: begin
        if (!p_empty) begin
          res.read_data  = p_dout;
          res.data_valid = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      bank_select <= '0;
      irq_flag    <= '0;
      irq_enable  <= 5'h1F;
      request_reg <= '0;
      sector_pos  <= '0;
      sector_len  <= '0;
      volume_regs[0] <= 8'h80;
      volume_regs[1] <= 8'h80;
      volume_regs[2] <= 8'h00;
      volume_regs[3] <= 8'h00;
    end else if (accept) begin
      if (sec_rd) begin
        sector_pos <= sector_pos + 1'b1;
      end
      unique case (cmd)
        CMD_BUS_WRITE: begin
          unique case (in_word.reg_offset)
            REG_STATUS: bank_select <= in_word.write_value[1:0];
            REG_ONE: if (bank_select == 2'd3) volume_regs[1] <= in_word.write_value;
            REG_TWO: begin
              unique case (bank_select)
                2'd0:    ;
                2'd1:    irq_enable <= in_word.write_value[4:0];
                2'd2:    volume_regs[0] <= in_word.write_value;
                default: volume_regs[3] <= in_word.write_value;
              endcase
            end
            default: begin
              unique case (bank_select)
                2'd0: begin
                  request_reg <= in_word.write_value;
                  if (in_word.write_value[7]) sector_pos <= '0;
                end
                2'd1: irq_flag <= irq_flag & ~{2'b00, in_word.write_value[2:0]};
                2'd2: volume_regs[2] <= in_word.write_value;
                default: ;
              endcase
            end
          endcase
        end
        CMD_RAISE_IRQ: irq_flag <= {2'b00, in_word.interrupt_kind};
        CMD_SECTOR_RDY: begin
          sector_len <= raw_sector_mode ? RawLenSat : DataLenSat;
          sector_pos <= '0;
        end
        default: ;
      endcase
    end
  end

  // Output register; the sector byte is picked after the memory read.
  out_word_t res_q;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sec_sel   <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= accept;
      sec_sel   <= sec_rd;
    end
    if (!in_stall) begin
      res_q <= res;
    end
  end

  // Sector byte must be read at pos before update; hold it with its word.
  logic [7:0] sec_hold;
  logic       held;
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= in_stall;
    end
    if (!held) begin
      sec_hold <= sec_q;
    end
  end

  always_comb begin
    out_word = res_q;
    if (sec_sel) begin
      out_word.read_data = held ? sec_hold : sec_q;
    end
  end

  `ODHRI_ASSERT(a_stall_holds_out, clk, rst, in_stall |=> out_valid)
  `ODHRI_ASSERT(a_cmd_excl, clk, rst, out_valid |-> !(out_word.command_valid && out_word.data_valid))
  `ODHRI_ASSERT(a_pos_bound, clk, rst, sector_pos <= sector_len || $past(accept))
endmodule

// ===== tb/optical_drive_host_register_interface_tb.sv =====
// Self-checking testbench for the optical drive host register interface.
module optical_drive_host_register_interface_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import odhri_pkg::*;

  localparam int QueueDepth   = FifoDepthDefault;
  localparam int SectorBytes  = SectorBufBytesDefault;
  localparam int IdleLimit    = 2000;
  localparam int RandomWords  = 1100;
  localparam int InBits       = $bits(in_word_t);

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_word_t   in_word = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_word_t  out_word;
  logic       cfg_we = 1'b0;
  logic       cfg_index = 1'b0;
  logic       cfg_data = 1'b0;

  optical_drive_host_register_interface u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Shadow copy of the host-visible state. Volume registers are write-only
  // from the bus, so they are not tracked.
  logic        adpcm_on;
  logic        raw_on;
  logic [1:0]  bank;
  logic [7:0]  param_queue[$];
  logic [7:0]  resp_fifo[$];
  logic [4:0]  irq_flag;
  logic [4:0]  irq_mask;
  logic [7:0]  request_byte;
  logic [7:0]  sector_mem[SectorBytes];
  bit          sector_loaded[SectorBytes];
  int          sector_pos;
  int          sector_len;

  out_word_t   pending_words[$];
  int          errors = 0;
  bit          calm = 1'b0;
  int          stall_left = 0;
  int          idle_cycles = 0;

  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t e;
  } dir_row_t;
  dir_row_t dir_rows[$];

  // Advance the shadow state by one word and return the word it yields.
  function automatic out_word_t host_response(in_word_t w);
    out_word_t r;
    logic [1:0] bk;
    r = '0;
    bk = bank;
    case (cmd_t'(w.command))
      CMD_BUS_READ: begin
        case (w.reg_offset)
          REG_STATUS: r.read_data = {1'b0, request_byte[7], resp_fifo.size() != 0,
                                     param_queue.size() < QueueDepth,
                                     param_queue.size() == 0, adpcm_on, bank};
          REG_ONE: if (resp_fifo.size() != 0) r.read_data = resp_fifo.pop_front();
          REG_TWO: if (sector_pos < sector_len) begin
            r.read_data = sector_mem[sector_pos[11:0]];
            sector_pos++;
          end
          default: r.read_data = {3'b111, bank[0] ? irq_flag : irq_mask};
        endcase
      end
      CMD_BUS_WRITE: begin
        case (w.reg_offset)
          REG_STATUS: bank = w.write_value[1:0];
          REG_ONE: if (bk == 2'd0) begin
            r.command_valid = 1'b1;
            r.command_code = w.write_value[4:0];
          end
          REG_TWO: begin
            if (bk == 2'd0 && param_queue.size() < QueueDepth)
              param_queue.push_back(w.write_value);
            else if (bk == 2'd1)
              irq_mask = w.write_value[4:0];
          end
          default: begin
            if (bk == 2'd0) begin
              request_byte = w.write_value;
              if (w.write_value[7]) sector_pos = 0;
            end else if (bk == 2'd1) begin
              // acknowledge: clear the named flag bits and flush responses; bit 6 flushes parameters
              if (w.write_value[2:0] != 3'd0) begin
                irq_flag = irq_flag & ~{2'b00, w.write_value[2:0]};
                resp_fifo.delete();
              end
              if (w.write_value[6]) param_queue.delete();
            end
          end
        endcase
      end
      CMD_PUSH_RESP: begin
        if (w.clear_first) resp_fifo.delete();
        if (resp_fifo.size() < QueueDepth) resp_fifo.push_back(w.drive_byte);
      end
      CMD_RAISE_IRQ: begin
        irq_flag = {2'b00, w.interrupt_kind};
        r.irq_request = 1'b1;
      end
      CMD_POP_PARAM: if (param_queue.size() != 0) begin
        r.read_data = param_queue.pop_front();
        r.data_valid = 1'b1;
      end
      CMD_LOAD_SECTOR: begin
        sector_mem[w.sector_index] = w.drive_byte;
        sector_loaded[w.sector_index] = 1'b1;
      end
      CMD_SECTOR_RDY: begin
        sector_len = raw_on ? RawSectorLenDefault : DataSectorLenDefault;
        if (sector_len > SectorBytes) sector_len = SectorBytes;
        sector_pos = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Output side: check each result, then decide the stall for the next cycle.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_words.size() == 0) begin
          report("unexpected word", int'(out_word), 0);
        end else begin
          out_word_t e;
          e = pending_words.pop_front();
          if (out_word.read_data != e.read_data)
            report("read_data", out_word.read_data, e.read_data);
          if (out_word.data_valid != e.data_valid)
            report("data_valid", out_word.data_valid, e.data_valid);
          if (out_word.command_valid != e.command_valid)
            report("command_valid", out_word.command_valid, e.command_valid);
          if (out_word.command_code != e.command_code)
            report("command_code", out_word.command_code, e.command_code);
          if (out_word.irq_request != e.irq_request)
            report("irq_request", out_word.irq_request, e.irq_request);
        end
      end
      if (calm) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 16);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run if no word moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("optical_drive_host_register_interface test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Drive one word, hold it until accepted, then predict its result.
  // A typed expectation replaces the predicted one for directed rows.
  task automatic send(input in_word_t w, input bit typed = 1'b0,
                      input out_word_t e = '0);
    out_word_t p;
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    p = host_response(w);
    pending_words.push_back(typed ? e : p);
  endtask

  // Wait for the block to drain, then write both mode registers.
  task automatic set_modes(input logic adpcm, input logic raw);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_ADPCM;
    cfg_data <= adpcm;
    @(posedge clk);
    cfg_index <= CFG_RAW;
    cfg_data <= raw;
    @(posedge clk);
    cfg_we <= 1'b0;
    adpcm_on = adpcm;
    raw_on = raw;
  endtask

  function automatic in_word_t any_word();
    in_word_t w;
    w = in_word_t'(InBits'({$urandom, $urandom}));
    if (w.command == CMD_UNUSED && $urandom_range(0, 3) != 0) w.command = CMD_BUS_READ;
    return w;
  endfunction

  function automatic in_word_t cmd_word(cmd_t c, logic [1:0] off, logic [7:0] val);
    in_word_t w;
    w = any_word();
    w.command = c;
    w.reg_offset = off;
    w.write_value = val;
    return w;
  endfunction

  // Send a word, steering sector reads away from bytes that were never loaded:
  // load the byte at the current position instead.
  task automatic send_safe(input in_word_t w);
    if (w.command == CMD_BUS_READ && w.reg_offset == REG_TWO &&
        sector_pos < sector_len && !sector_loaded[sector_pos[11:0]]) begin
      w.command = CMD_LOAD_SECTOR;
      w.sector_index = sector_pos[11:0];
    end
    send(w);
  endtask

  task automatic random_traffic(input int count);
    int sent;
    int k;
    int j;
    in_word_t w;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 5))
        0: begin
          // fill the parameter queue, sometimes past full, then drain it
          send_safe(cmd_word(CMD_BUS_WRITE, REG_STATUS, {6'($urandom_range(0, 63)), 2'b00}));
          k = $urandom_range(1, 20);
          repeat (k) send_safe(cmd_word(CMD_BUS_WRITE, REG_TWO, 8'($urandom)));
          send_safe(cmd_word(CMD_BUS_READ, REG_STATUS, 8'h00));
          j = $urandom_range(1, 20);
          repeat (j) send_safe(cmd_word(CMD_POP_PARAM, 2'd0, 8'h00));
          sent += k + j + 2;
        end
        1: begin
          k = $urandom_range(1, 20);
          repeat (k) begin
            w = cmd_word(CMD_PUSH_RESP, 2'd0, 8'h00);
            w.clear_first = ($urandom_range(0, 15) == 0);
            send_safe(w);
          end
          send_safe(cmd_word(CMD_BUS_READ, REG_STATUS, 8'h00));
          j = $urandom_range(1, 20);
          repeat (j) send_safe(cmd_word(CMD_BUS_READ, REG_ONE, 8'h00));
          sent += k + j + 1;
        end
        2: begin
          send_safe(cmd_word(CMD_SECTOR_RDY, 2'd0, 8'h00));
          k = $urandom_range(1, 30);
          repeat (k) begin
            if ($urandom_range(0, 2) == 0) begin
              w = cmd_word(CMD_LOAD_SECTOR, 2'd0, 8'h00);
              w.sector_index = 12'((sector_pos + $urandom_range(0, 3)) % SectorBytes);
            end else begin
              w = cmd_word(CMD_BUS_READ, REG_TWO, 8'h00);
            end
            send_safe(w);
          end
          sent += k + 1;
        end
        3: begin
          send_safe(cmd_word(CMD_RAISE_IRQ, 2'd0, 8'h00));
          send_safe(cmd_word(CMD_BUS_WRITE, REG_STATUS, 8'($urandom_range(0, 3))));
          send_safe(cmd_word(CMD_BUS_READ, REG_THREE, 8'h00));
          send_safe(cmd_word(CMD_BUS_WRITE, REG_TWO, 8'($urandom)));
          send_safe(cmd_word(CMD_BUS_WRITE, REG_THREE, 8'($urandom)));
          send_safe(cmd_word(CMD_BUS_READ, REG_THREE, 8'h00));
          send_safe(cmd_word(CMD_BUS_WRITE, REG_ONE, 8'($urandom)));
          sent += 7;
        end
        default: begin
          repeat (8) send_safe(any_word());
          sent += 8;
        end
      endcase
    end
  endtask

  function automatic void add_row(cmd_t c, logic [1:0] off, logic [7:0] val,
                                  bit typed, out_word_t e);
    dir_row_t r;
    r.w = '0;
    r.w.command = c;
    r.w.reg_offset = off;
    r.w.write_value = val;
    r.w.drive_byte = val;
    r.w.interrupt_kind = val[2:0];
    r.w.sector_index = {val, val[3:0]};
    r.w.clear_first = val[0];
    r.typed = typed;
    r.e = e;
    dir_rows.push_back(r);
  endfunction

  // Directed rows: the sector read rows follow a load of byte 0, so they
  // never touch an unloaded byte; the second one reads past it and is guarded.
  task automatic send_safe_row(input dir_row_t r);
    if (r.typed) send(r.w, 1'b1, r.e);
    else send_safe(r.w);
  endtask

  initial begin
    adpcm_on = 1'b0;
    raw_on = 1'b0;
    bank = 2'd0;
    irq_flag = '0;
    irq_mask = 5'h1F;
    request_byte = '0;
    sector_pos = 0;
    sector_len = 0;

    // after reset: status, mask, empty reads, extremes, every command
    add_row(CMD_BUS_READ,    REG_STATUS, 8'h00, 1, '{8'h18, 1'b0, 1'b0, 5'd0, 1'b0});
    add_row(CMD_BUS_READ,    REG_THREE,  8'h00, 1, '{8'hFF, 1'b0, 1'b0, 5'd0, 1'b0});
    add_row(CMD_BUS_READ,    REG_ONE,    8'h00, 1, '{8'h00, 1'b0, 1'b0, 5'd0, 1'b0});
    add_row(CMD_BUS_READ,    REG_TWO,    8'h00, 1, '{8'h00, 1'b0, 1'b0, 5'd0, 1'b0});
    add_row(CMD_POP_PARAM,   REG_STATUS, 8'h00, 1, '{8'h00, 1'b0, 1'b0, 5'd0, 1'b0});
    add_row(CMD_UNUSED,      REG_THREE,  8'hFF, 1, '{8'h00, 1'b0, 1'b0, 5'd0, 1'b0});
    add_row(CMD_BUS_WRITE,   REG_ONE,    8'hFF, 1, '{8'h00, 1'b0, 1'b1, 5'h1F, 1'b0});
    add_row(CMD_RAISE_IRQ,   REG_STATUS, 8'hFF, 1, '{8'h00, 1'b0, 1'b0, 5'd0, 1'b1});
    add_row(CMD_BUS_WRITE,   REG_TWO,    8'h00, 0, '0);
    add_row(CMD_BUS_WRITE,   REG_TWO,    8'hFF, 0, '0);
    add_row(CMD_BUS_READ,    REG_STATUS, 8'h00, 0, '0);
    add_row(CMD_POP_PARAM,   REG_STATUS, 8'h00, 0, '0);
    add_row(CMD_PUSH_RESP,   REG_STATUS, 8'hFF, 0, '0);
    add_row(CMD_PUSH_RESP,   REG_STATUS, 8'h00, 0, '0);
    add_row(CMD_BUS_READ,    REG_ONE,    8'h00, 0, '0);
    add_row(CMD_BUS_WRITE,   REG_STATUS, 8'h01, 0, '0);
    add_row(CMD_BUS_READ,    REG_THREE,  8'h00, 0, '0);
    add_row(CMD_BUS_WRITE,   REG_TWO,    8'h00, 0, '0);
    add_row(CMD_RAISE_IRQ,   REG_STATUS, 8'h05, 0, '0);
    add_row(CMD_BUS_WRITE,   REG_THREE,  8'h47, 0, '0);
    add_row(CMD_BUS_READ,    REG_THREE,  8'h00, 0, '0);
    add_row(CMD_LOAD_SECTOR, REG_STATUS, 8'h00, 0, '0);
    add_row(CMD_SECTOR_RDY,  REG_STATUS, 8'h00, 0, '0);
    add_row(CMD_BUS_READ,    REG_TWO,    8'h00, 0, '0);
    add_row(CMD_BUS_READ,    REG_TWO,    8'h00, 0, '0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) send_safe_row(dir_rows[i]);

    set_modes(1'b1, 1'b1);
    random_traffic(RandomWords / 4);
    set_modes(1'b0, 1'b1);
    random_traffic(RandomWords / 4);
    set_modes(1'b1, 1'b0);
    random_traffic(RandomWords / 4);
    set_modes(1'b0, 1'b0);
    calm = 1'b1;
    random_traffic(RandomWords / 4);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0)
      $display("optical_drive_host_register_interface test passed");
    else
      $display("optical_drive_host_register_interface test failed");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/odhri_pkg.sv
rtl/odhri_fifo.sv
rtl/optical_drive_host_register_interface.sv
tb/optical_drive_host_register_interface_tb.sv
